FILE: rtl/core/apid_pkg.sv
`default_nettype none

package apid_pkg;

  // Fixed field widths of the register set and the result
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned OLIM_W     = 15;
  localparam int unsigned ILIM_W     = 23;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned DRIVE_W    = 16;
  localparam int unsigned INTEG_W    = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 23;

  // Effective gains after adaptive scaling stay below 2^17
  localparam int unsigned KW         = 17;
  // Multiplier A operand: gains and scaled gain numerators (< 2^19), plus sign
  localparam int unsigned MUL_A_W    = 20;

  // floor(x / 5) = (x * RECIP5) >> RECIP_SHIFT, exact for x < 2^22
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [22:0] RECIP5      = 23'd3355444;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_KP        = 3'd0;
  localparam cfg_idx_t REG_KI        = 3'd1;
  localparam cfg_idx_t REG_KD        = 3'd2;
  localparam cfg_idx_t REG_OUT_LIMIT = 3'd3;
  localparam cfg_idx_t REG_INT_LIMIT = 3'd4;
  localparam cfg_idx_t REG_ADAPT_EN  = 3'd5;
  localparam cfg_idx_t REG_ADAPT_THR = 3'd6;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [OLIM_W-1:0] olim;
    logic [ILIM_W-1:0] ilim;
    logic              aen;
    logic [THR_W-1:0]  thr;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    kp:   '0,
    ki:   '0,
    kd:   '0,
    olim: 15'h7FFF,
    ilim: 23'h7FFFFF,
    aen:  1'b0,
    thr:  '0
  };

endpackage

`default_nettype wire

FILE: rtl/core/apid_if.sv
`default_nettype none

interface apid_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic signed [SAMPLE_WIDTH-1:0] setpoint;
  logic signed [SAMPLE_WIDTH-1:0] measured;

  modport source (output valid, op, setpoint, measured, input ready);
  modport sink   (input valid, op, setpoint, measured, output ready);
endinterface

interface apid_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/apid_cfg.sv
`default_nettype none

module apid_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  apid_pkg::cfg_idx_t                  idx_i,
  input  logic [apid_pkg::CFG_DATA_W-1:0]     wdata_i,
  output apid_pkg::cfg_t                      cfg_o
);
  import apid_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        REG_KP:        cfg_d.kp   = wdata_i[GAIN_W-1:0];
        REG_KI:        cfg_d.ki   = wdata_i[GAIN_W-1:0];
        REG_KD:        cfg_d.kd   = wdata_i[GAIN_W-1:0];
        REG_OUT_LIMIT: cfg_d.olim = wdata_i[OLIM_W-1:0];
        REG_INT_LIMIT: cfg_d.ilim = wdata_i[ILIM_W-1:0];
        REG_ADAPT_EN:  cfg_d.aen  = wdata_i[0];
        REG_ADAPT_THR: cfg_d.thr  = wdata_i[THR_W-1:0];
        default:       cfg_d      = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/apid_mul.sv
`default_nettype none

module apid_mul #(
  parameter int unsigned AW = 20,
  parameter int unsigned BW = 26
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [AW-1:0]        a_i,
  input  logic signed [BW-1:0]        b_i,
  output logic signed [AW+BW-1:0]     p_o
);

  logic signed [AW+BW-1:0] p_q;

  // Product is held until the sequencer issues the next operand pair
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/core/adaptive_pid_antiwindup.sv
// Channel   Dir  Handshake     Payload
// sample_i  in   valid/ready   op, setpoint, measured (signed SAMPLE_WIDTH)
// result_o  out  valid/ready   drive (signed 16)
// cfg       in   cfg_we_i      cfg_idx_i, cfg_wdata_i (no wait, no read-back)
//
// An update runs S_PREP, the gain-scaling steps (S_ADJ0, S_ADJ1, S_ADJ3 on a
// large error, S_ADJ0 to S_ADJ3 on a small one, none with base gains), then
// S_MP to S_OUT; a clear goes straight to S_OUT. The steps follow from the one
// registered multiplier that serves gain scaling and the P, I and D products.
// Reset (rst_ni low, asynchronous) loads default registers, zeroes the
// integral and previous error and sets the first-sample flag.
// One result register decouples the output: the next sample is taken while a
// result waits, and the sequencer holds in its last step while it is full.
`default_nettype none

module adaptive_pid_antiwindup #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  apid_in_if.sink                         sample_i,
  apid_out_if.source                      result_o,
  input  logic                            cfg_we_i,
  input  apid_pkg::cfg_idx_t              cfg_idx_i,
  input  logic [apid_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import apid_pkg::*;

  localparam int unsigned EW     = SAMPLE_WIDTH + 1;
  localparam int unsigned DW     = SAMPLE_WIDTH + 2;
  localparam int unsigned TW     = ((INTEG_W > EW) ? INTEG_W : EW) + 1;
  localparam int unsigned BW0    = (DW > TW) ? DW : TW;
  localparam int unsigned BW     = (BW0 > 24) ? BW0 : 24;
  localparam int unsigned PW     = MUL_A_W + BW;
  localparam int unsigned ACC_W  = PW + 2;
  localparam int unsigned CW     = (EW > THR_W) ? EW : THR_W;
  localparam int unsigned LW     = OLIM_W + GAIN_FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_ADJ0, S_ADJ1, S_ADJ2, S_ADJ3,
    S_MP, S_MI, S_MC, S_MI2, S_MD, S_MF, S_OUT
  } state_e;

  cfg_t cfg;

  state_e                     state_q;
  logic signed [EW-1:0]       err_q;
  logic signed [EW-1:0]       prev_q;
  logic signed [DW-1:0]       deriv_q;
  logic signed [TW-1:0]       integ_q;
  logic signed [INTEG_W-1:0]  eint_q;
  logic                       first_q;
  logic                       large_q;
  logic [KW-1:0]              kp_q, ki_q, kd_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [DRIVE_W-1:0]         res_q;
  logic                       out_valid_q;
  logic [DRIVE_W-1:0]         out_drive_q;

  logic                       in_ready;
  logic                       in_xfer;
  logic signed [SAMPLE_WIDTH-1:0] sp, ms;

  logic                       mul_en;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [BW-1:0]       mul_b;
  logic signed [PW-1:0]       prod;

  logic [MUL_A_W-1:0]         kp4, ki3, ki6, kd6;
  logic [KW:0]                kp3;
  logic [KW:0]                kp2;
  logic [KW-1:0]              quot;
  logic [EW-1:0]              err_mag;
  logic signed [ACC_W-1:0]    sum;
  logic signed [ACC_W-1:0]    lim_s;
  logic signed [TW-1:0]       ilim_s;
  logic                       wind_hi, wind_lo;
  logic signed [TW-1:0]       integ_sel, integ_clamp;
  logic signed [ACC_W-1:0]    o_clamp, o_shift;

  apid_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  apid_mul #(
    .AW (MUL_A_W),
    .BW (BW)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign in_ready       = (state_q == S_IDLE);
  assign in_xfer        = sample_i.valid && in_ready;
  assign sample_i.ready = in_ready;
  assign sp             = sample_i.setpoint;
  assign ms             = sample_i.measured;

  assign result_o.valid = out_valid_q;
  assign result_o.drive = out_drive_q;

  // Scaled gain numerators; kp4, ki3, ki6 and kd6 go through the reciprocal multiply for /5
  assign kp4  = MUL_A_W'({cfg.kp, 2'b00});
  assign ki3  = MUL_A_W'(cfg.ki) + MUL_A_W'({cfg.ki, 1'b0});
  assign ki6  = MUL_A_W'({cfg.ki, 1'b0}) + MUL_A_W'({cfg.ki, 2'b00});
  assign kd6  = MUL_A_W'({cfg.kd, 1'b0}) + MUL_A_W'({cfg.kd, 2'b00});
  assign kp3  = (KW+1)'(cfg.kp) + (KW+1)'({cfg.kp, 1'b0});
  assign kp2  = {kp_q, 1'b0};
  assign quot = prod[RECIP_SHIFT +: KW];

  assign err_mag = err_q[EW-1] ? EW'(-err_q) : EW'(err_q);

  assign sum    = acc_q + ACC_W'(prod);
  assign lim_s  = ACC_W'(LW'(cfg.olim) << GAIN_FRAC_BITS);
  assign ilim_s = TW'(cfg.ilim);

  // Anti-windup: drop the new error from the integral when P+I saturates
  assign wind_hi   = (sum > lim_s);
  assign wind_lo   = (sum < -lim_s);
  assign integ_sel = (wind_hi || wind_lo) ? TW'(eint_q) : integ_q;

  always_comb begin
    if (integ_sel > ilim_s) begin
      integ_clamp = ilim_s;
    end else if (integ_sel < -ilim_s) begin
      integ_clamp = -ilim_s;
    end else begin
      integ_clamp = integ_sel;
    end
  end

  always_comb begin
    if (sum > lim_s) begin
      o_clamp = lim_s;
    end else if (sum < -lim_s) begin
      o_clamp = -lim_s;
    end else begin
      o_clamp = sum;
    end
  end

  assign o_shift = o_clamp >>> GAIN_FRAC_BITS;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_ADJ0: begin
        mul_en = 1'b1;
        mul_a  = large_q ? ki6 : kp4;
        mul_b  = BW'(RECIP5);
      end
      S_ADJ1: begin
        mul_en = !large_q;
        mul_a  = ki3;
        mul_b  = BW'(RECIP5);
      end
      S_ADJ2: begin
        mul_en = 1'b1;
        mul_a  = kd6;
        mul_b  = BW'(RECIP5);
      end
      S_MP: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(kp_q);
        mul_b  = BW'(err_q);
      end
      S_MI, S_MI2: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(ki_q);
        mul_b  = BW'(integ_q);
      end
      S_MD: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(kd_q);
        mul_b  = BW'(deriv_q);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      err_q       <= '0;
      prev_q      <= '0;
      deriv_q     <= '0;
      integ_q     <= '0;
      eint_q      <= '0;
      first_q     <= 1'b1;
      large_q     <= 1'b0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      acc_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_drive_q <= '0;
    end else begin
      // S_OUT refills the result register itself
      if (result_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (sample_i.op == OP_CLEAR) begin
              eint_q  <= '0;
              prev_q  <= '0;
              first_q <= 1'b1;
              res_q   <= '0;
              state_q <= S_OUT;
            end else begin
              err_q   <= EW'(sp) - EW'(ms);
              state_q <= S_PREP;
            end
          end
        end
        S_PREP: begin
          // First sample: derivative is zero
          deriv_q <= first_q ? '0 : DW'(err_q) - DW'(prev_q);
          prev_q  <= err_q;
          first_q <= 1'b0;
          integ_q <= TW'(eint_q) + TW'(err_q);
          large_q <= CW'(err_mag) > CW'(cfg.thr);
          if (cfg.aen && (cfg.kp != '0)) begin
            state_q <= S_ADJ0;
          end else begin
            kp_q    <= KW'(cfg.kp);
            ki_q    <= KW'(cfg.ki);
            kd_q    <= KW'(cfg.kd);
            state_q <= S_MP;
          end
        end
        S_ADJ0: begin
          state_q <= S_ADJ1;
        end
        S_ADJ1: begin
          if (large_q) begin
            ki_q    <= quot;
            kp_q    <= kp3[KW:1];
            kd_q    <= KW'(cfg.kd);
            state_q <= S_ADJ3;
          end else begin
            kp_q    <= quot;
            state_q <= S_ADJ2;
          end
        end
        S_ADJ2: begin
          ki_q    <= quot;
          state_q <= S_ADJ3;
        end
        S_ADJ3: begin
          if (!large_q) begin
            kd_q <= quot;
          end
          if ((KW+1)'(ki_q) > kp2) begin
            ki_q <= kp2[KW-1:0];
          end
          state_q <= S_MP;
        end
        S_MP: begin
          state_q <= S_MI;
        end
        S_MI: begin
          acc_q   <= ACC_W'(prod);
          state_q <= S_MC;
        end
        S_MC: begin
          integ_q <= integ_clamp;
          eint_q  <= INTEG_W'(integ_clamp);
          state_q <= S_MI2;
        end
        S_MI2: begin
          state_q <= S_MD;
        end
        S_MD: begin
          acc_q   <= sum;
          state_q <= S_MF;
        end
        S_MF: begin
          res_q   <= o_shift[DRIVE_W-1:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          // Hold until the result register is free
          if (!out_valid_q || result_o.ready) begin
            out_valid_q <= 1'b1;
            out_drive_q <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/apid_chk.sv
`default_nettype none

module apid_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            in_op_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [apid_pkg::DRIVE_W-1:0]    out_drive_i
);
  import apid_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // Sequencer is busy right after taking a sample
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input ready right after a transfer");

  // Drive is clamped symmetrically, so the most negative code never shows
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_drive_i != {1'b1, {(DRIVE_W-1){1'b0}}}))
    else $error("drive outside symmetric range");

  // Clear with an empty result register passes through S_OUT, then returns a zero drive
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_op_i == OP_CLEAR) && !out_valid_i)
      |=> ##1 (out_valid_i && (out_drive_i == '0)))
    else $error("clear did not return a zero drive");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_drive_i)))
    else $error("stalled result changed");

endmodule

bind adaptive_pid_antiwindup apid_chk u_apid_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .in_op_i     (sample_i.op),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_drive_i (result_o.drive)
);

`default_nettype wire
